// ----- sv/dad_pkg.sv -----
// Shared types, constants and the control store for the date adder.
// Depends on nothing; date_add_days_unit imports it.
`timescale 1ns / 1ps

package dad_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned OffW   = 17;
  localparam int unsigned UpcW   = 3;

  // Working widths: the year may step a little below 0 or above the top year,
  // and the day register holds the raw sum of day and offset.
  localparam int unsigned YearAccW = 16;
  localparam int unsigned DayAccW  = 18;
  localparam int unsigned ModW     = 9;

  localparam logic [YearW-1:0]  YearMax    = 14'd16383;
  localparam logic [MonthW-1:0] MonthJan   = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb   = 4'd2;
  localparam logic [MonthW-1:0] MonthDec   = 4'd12;
  localparam logic [ModW-1:0]   Cycle400   = 9'd400;
  localparam logic [ModW-1:0]   Cycle400M1 = 9'd399;

  // Datapath operations selected by a control word
  typedef enum logic [2:0] {
    OP_LOAD,   // take a new word from the input
    OP_MOD,    // reduce the start year modulo 400
    OP_FWD,    // roll surplus days into the next month
    OP_BWD,    // borrow days from the previous month
    OP_EMIT    // write the result register
  } op_e;

  // Branch conditions
  typedef enum logic [2:0] {
    C_IN,      // input word offered
    C_GE400,   // year remainder still 400 or more
    C_DGT,     // day beyond length of current month
    C_DLE0,    // day zero or negative
    C_OSLOT    // result register free
  } cond_e;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [UpcW-1:0] jt;   // next step when the condition holds
    logic [UpcW-1:0] jf;   // next step otherwise
  } uword_t;

  localparam logic [UpcW-1:0] UpcLoad = 3'd0;
  localparam logic [UpcW-1:0] UpcMod  = 3'd1;
  localparam logic [UpcW-1:0] UpcFwd  = 3'd2;
  localparam logic [UpcW-1:0] UpcBwd  = 3'd3;
  localparam logic [UpcW-1:0] UpcEmit = 3'd4;

  // Control store: one word per step
  function automatic uword_t ucode_rom(input logic [UpcW-1:0] upc);
    uword_t w;
    unique case (upc)
      UpcLoad: w = '{op: OP_LOAD, cond: C_IN,    jt: UpcMod,  jf: UpcLoad};
      UpcMod:  w = '{op: OP_MOD,  cond: C_GE400, jt: UpcMod,  jf: UpcFwd};
      UpcFwd:  w = '{op: OP_FWD,  cond: C_DGT,   jt: UpcFwd,  jf: UpcBwd};
      UpcBwd:  w = '{op: OP_BWD,  cond: C_DLE0,  jt: UpcBwd,  jf: UpcEmit};
      UpcEmit: w = '{op: OP_EMIT, cond: C_OSLOT, jt: UpcLoad, jf: UpcEmit};
      default: w = '{op: OP_LOAD, cond: C_IN,    jt: UpcMod,  jf: UpcLoad};
    endcase
    return w;
  endfunction

  // Days in a month; leap selects 29 for February
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] len;
    unique case (m)
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      MonthFeb:                len = leap ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ----- sv/date_add_days_unit.sv -----
// Top level of the Gregorian date adder: stream ports, microcoded sequencer
// and its datapath. Depends on dad_pkg.
`timescale 1ns / 1ps

// Adds a signed day offset to a Gregorian date and returns the normalized
// date, or the input date with out_of_range set when the result year leaves
// 0..16383. One word is in work at a time. A word is loaded, its start year
// is reduced modulo 400 by repeated subtraction, surplus days are rolled into
// following months one month at a time, then days are borrowed from earlier
// months while the day is zero or negative, and the result is emitted. The
// result sits in an output register, so the next word is taken while the
// previous result waits to be read.
module date_add_days_unit
  import dad_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [13:0] start_year, [17:14] start_month, [22:18] start_day,
  // [39:23] day_offset (signed)
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [13:0] result_year, [17:14] result_month, [22:18] result_day, [23] zero
  output logic [23:0] m_axis_tdata,
  // [0] out_of_range
  output logic [0:0]  m_axis_tuser
);

  // Input fields
  logic [YearW-1:0]  in_year;
  logic [MonthW-1:0] in_month;
  logic [DayW-1:0]   in_day;
  logic [OffW-1:0]   in_off;

  assign in_year  = s_axis_tdata[13:0];
  assign in_month = s_axis_tdata[17:14];
  assign in_day   = s_axis_tdata[22:18];
  assign in_off   = s_axis_tdata[39:23];

  // Sequencer and datapath registers
  logic [UpcW-1:0]            upc_q, upc_d;
  logic signed [YearAccW-1:0] y_q, y_d;
  logic [MonthW-1:0]          m_q, m_d;
  logic signed [DayAccW-1:0]  d_q, d_d;
  logic [ModW-1:0]            c_q, c_d;      // year mod 400
  logic [YearW-1:0]           t_q, t_d;      // remainder during reduction
  logic [YearW-1:0]           y0_q;
  logic [MonthW-1:0]          m0_q;
  logic [DayW-1:0]            d0_q;

  logic                       ovalid_q, ovalid_d;
  logic [YearW-1:0]           oyear_q, oyear_d;
  logic [MonthW-1:0]          omonth_q, omonth_d;
  logic [DayW-1:0]            oday_q, oday_d;
  logic                       oor_q, oor_d;

  uword_t                     uw;
  logic                       hit;
  logic                       leap;
  logic                       div100;
  logic [MonthW-1:0]          m_prev;
  logic [MonthW-1:0]          m_first;
  logic [DayW-1:0]            len_cur;
  logic [DayW-1:0]            len_prev;
  logic [ModW-1:0]            c_inc;
  logic [ModW-1:0]            c_dec;
  logic                       oor;

  assign uw = ucode_rom(upc_q);

  // Leap rule from the low year bits and the mod-400 counter
  assign div100 = (c_q == 9'd0) || (c_q == 9'd100) || (c_q == 9'd200) ||
                  (c_q == 9'd300);
  assign leap   = ((y_q[1:0] == 2'b00) && !div100) || (c_q == 9'd0);

  assign m_prev   = (m_q == MonthJan) ? MonthDec : m_q - 4'd1;
  assign len_cur  = month_len(m_q, leap);
  assign len_prev = month_len(m_prev, leap);
  assign c_inc    = (c_q == Cycle400M1) ? '0 : c_q + 9'd1;
  assign c_dec    = (c_q == '0) ? Cycle400M1 : c_q - 9'd1;

  // Clamp the start month into 1..12
  assign m_first = (in_month == '0) ? MonthJan :
                   (in_month > MonthDec) ? MonthDec : in_month;

  assign oor = y_q[YearAccW-1] || (y_q > $signed({2'b00, YearMax}));

  // Branch condition for the current step
  always_comb begin
    unique case (uw.cond)
      C_IN:    hit = s_axis_tvalid;
      C_GE400: hit = ({1'b0, t_q} >= {6'd0, Cycle400});
      C_DGT:   hit = (d_q > $signed({{(DayAccW-DayW){1'b0}}, len_cur}));
      C_DLE0:  hit = d_q[DayAccW-1] || (d_q == '0);
      C_OSLOT: hit = !ovalid_q || m_axis_tready;
      default: hit = 1'b0;
    endcase
  end

  assign s_axis_tready = (uw.op == OP_LOAD);

  // Datapath driven by the control word
  always_comb begin
    upc_d    = hit ? uw.jt : uw.jf;
    y_d      = y_q;
    m_d      = m_q;
    d_d      = d_q;
    c_d      = c_q;
    t_d      = t_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    oyear_d  = oyear_q;
    omonth_d = omonth_q;
    oday_d   = oday_q;
    oor_d    = oor_q;
    unique case (uw.op)
      OP_LOAD: begin
        if (hit) begin
          y_d = $signed({2'b00, in_year});
          m_d = m_first;
          d_d = $signed({{(DayAccW-DayW){1'b0}}, in_day}) +
                $signed({in_off[OffW-1], in_off});
          t_d = in_year;
        end
      end
      OP_MOD: begin
        if (hit) begin
          t_d = t_q - {5'd0, Cycle400};
        end else begin
          c_d = t_q[ModW-1:0];
        end
      end
      OP_FWD: begin
        if (hit) begin
          d_d = d_q - $signed({{(DayAccW-DayW){1'b0}}, len_cur});
          if (m_q == MonthDec) begin
            m_d = MonthJan;
            y_d = y_q + 16'sd1;
            c_d = c_inc;
          end else begin
            m_d = m_q + 4'd1;
          end
        end
      end
      OP_BWD: begin
        if (hit) begin
          d_d = d_q + $signed({{(DayAccW-DayW){1'b0}}, len_prev});
          m_d = m_prev;
          if (m_q == MonthJan) begin
            y_d = y_q - 16'sd1;
            c_d = c_dec;
          end
        end
      end
      OP_EMIT: begin
        if (hit) begin
          ovalid_d = 1'b1;
          oor_d    = oor;
          if (oor) begin
            oyear_d  = y0_q;
            omonth_d = m0_q;
            oday_d   = d0_q;
          end else begin
            oyear_d  = y_q[YearW-1:0];
            omonth_d = m_q;
            oday_d   = d_q[DayW-1:0];
          end
        end
      end
      default: begin
        upc_d = UpcLoad;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q    <= UpcLoad;
      ovalid_q <= 1'b0;
    end else begin
      upc_q    <= upc_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    y_q      <= y_d;
    m_q      <= m_d;
    d_q      <= d_d;
    c_q      <= c_d;
    t_q      <= t_d;
    oyear_q  <= oyear_d;
    omonth_q <= omonth_d;
    oday_q   <= oday_d;
    oor_q    <= oor_d;
    if (s_axis_tvalid && s_axis_tready) begin
      y0_q <= in_year;
      m0_q <= in_month;
      d0_q <= in_day;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {1'b0, oday_q, omonth_q, oyear_q};
  assign m_axis_tuser  = oor_q;

endmodule
